### hdl/csvp_pkg.sv
// ----------------------------------------------------------------------------
// CSV row field parser package
// Item types, character constants, register indexes and helpers.
// ----------------------------------------------------------------------------
package csvp_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       field_end;
		logic       row_end;
	} out_item_t;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_UNKNOWN  = 2'd0;
	localparam kind_t KIND_QUOTED   = 2'd1;
	localparam kind_t KIND_UNQUOTED = 2'd2;

	localparam int unsigned CFG_INDEX_W = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_FIELD_SEPARATOR = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COMMENT_CHAR_A  = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_COMMENT_CHAR_B  = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_KEEP_COMMENTS   = 8'd3;

	localparam logic [7:0] SEPARATOR_RESET = 8'h2C;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
			(c == CH_FF) || (c == CH_CR);
	endfunction

endpackage

### hdl/csv_row_field_parser_core.sv
// ----------------------------------------------------------------------------
// CSV row field parser core
// Cleans CSV text one byte per item into field bytes, field ends and row ends.
// ----------------------------------------------------------------------------
// A result appears in the output register in the cycle after its item is accepted.
// Throughput: one item per cycle; the parse state updates in the accepting cycle.
// An item is accepted while the output register is empty or being taken.
// Reset clears the parse state, the output valid flag and the registers to
// their defaults (separator comma, no comment characters, comments dropped).
module csv_row_field_parser_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  csvp_pkg::in_item_t                     in_data,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output csvp_pkg::out_item_t                    out_data,
	input  logic                                   cfg_we,
	input  logic [csvp_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [7:0]                             cfg_wdata
);

	logic [7:0] sep_q;
	logic [7:0] comment_a_q;
	logic [7:0] comment_b_q;
	logic       keep_q;

	logic                in_comment_q, in_escape_q, in_quote_q, last_quote_q, row_data_q;
	csvp_pkg::kind_t     kind_q;
	logic                in_comment_d, in_escape_d, in_quote_d, last_quote_d, row_data_d;
	csvp_pkg::kind_t     kind_d;

	logic                out_valid_q;
	csvp_pkg::out_item_t out_q;

	logic                accept;
	logic                res_valid;
	csvp_pkg::out_item_t res;

	logic [7:0]      c;
	logic [7:0]      esc_c;
	logic            ws;
	logic            blank;
	logic            go;
	logic            do_data;
	logic [7:0]      data_c;
	logic            do_end_row;
	csvp_pkg::kind_t kind_eff;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q       <= csvp_pkg::SEPARATOR_RESET;
			comment_a_q <= '0;
			comment_b_q <= '0;
			keep_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				csvp_pkg::REG_FIELD_SEPARATOR: sep_q       <= cfg_wdata;
				csvp_pkg::REG_COMMENT_CHAR_A:  comment_a_q <= cfg_wdata;
				csvp_pkg::REG_COMMENT_CHAR_B:  comment_b_q <= cfg_wdata;
				csvp_pkg::REG_KEEP_COMMENTS:   keep_q      <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		c     = in_data.in_byte;
		ws    = (sep_q == 8'h00);
		blank = csvp_pkg::is_blank(c);

		in_comment_d = in_comment_q;
		in_escape_d  = in_escape_q;
		in_quote_d   = in_quote_q;
		last_quote_d = last_quote_q;
		row_data_d   = row_data_q;
		kind_d       = kind_q;

		res_valid  = 1'b0;
		res        = '0;
		do_data    = 1'b0;
		data_c     = c;
		do_end_row = 1'b0;
		go         = 1'b0;
		kind_eff   = kind_q;

		if (c == csvp_pkg::CH_N) begin
			esc_c = csvp_pkg::CH_LF;
		end else if (c == csvp_pkg::CH_R) begin
			esc_c = csvp_pkg::CH_CR;
		end else if (c == csvp_pkg::CH_T) begin
			esc_c = csvp_pkg::CH_TAB;
		end else begin
			esc_c = c;
		end

		priority if (in_data.end_of_input) begin
			do_end_row = 1'b1;
		end else if (in_comment_q) begin
			if (c == csvp_pkg::CH_LF) begin
				do_end_row = 1'b1;
			end else if (keep_q) begin
				row_data_d   = 1'b1;
				res_valid    = 1'b1;
				res.out_byte = c;
			end
		end else if (in_escape_q) begin
			in_escape_d = 1'b0;
			do_data     = 1'b1;
			data_c      = esc_c;
		end else begin
			go = 1'b1;
			if (kind_q == csvp_pkg::KIND_UNKNOWN) begin
				priority if (ws && blank) begin
					go = 1'b0;
				end else if (c != 8'h00 && (c == comment_a_q || c == comment_b_q)) begin
					go           = 1'b0;
					in_comment_d = 1'b1;
					if (keep_q) begin
						row_data_d   = 1'b1;
						res_valid    = 1'b1;
						res.out_byte = c;
					end
				end else if (c == csvp_pkg::CH_QUOTE) begin
					go           = 1'b0;
					kind_d       = csvp_pkg::KIND_QUOTED;
					in_quote_d   = 1'b1;
					last_quote_d = 1'b0;
				end else begin
					kind_eff = csvp_pkg::KIND_UNQUOTED;
					kind_d   = csvp_pkg::KIND_UNQUOTED;
				end
			end
			if (go) begin
				priority if (c == csvp_pkg::CH_QUOTE) begin
					in_quote_d = !in_quote_q;
					if (kind_eff == csvp_pkg::KIND_QUOTED) begin
						if (last_quote_q) begin
							last_quote_d = 1'b0;
							row_data_d   = 1'b1;
							res_valid    = 1'b1;
							res.out_byte = c;
						end else begin
							last_quote_d = 1'b1;
						end
					end else begin
						do_data = 1'b1;
					end
				end else if (c == csvp_pkg::CH_BSLASH) begin
					in_escape_d = 1'b1;
				end else if (!in_quote_q) begin
					priority if (c == csvp_pkg::CH_CR) begin
					end else if (c == csvp_pkg::CH_LF) begin
						do_end_row = 1'b1;
					end else if ((ws && blank) || c == sep_q) begin
						kind_d        = csvp_pkg::KIND_UNKNOWN;
						row_data_d    = 1'b1;
						last_quote_d  = 1'b0;
						res_valid     = 1'b1;
						res.field_end = 1'b1;
					end else begin
						do_data = 1'b1;
					end
				end else if (!(ws && blank)) begin
					do_data = 1'b1;
				end
			end
		end

		if (do_data) begin
			row_data_d   = 1'b1;
			last_quote_d = (data_c == csvp_pkg::CH_QUOTE);
			res_valid    = 1'b1;
			res.out_byte = data_c;
		end

		if (do_end_row) begin
			in_comment_d = 1'b0;
			in_escape_d  = 1'b0;
			in_quote_d   = 1'b0;
			kind_d       = csvp_pkg::KIND_UNKNOWN;
			last_quote_d = 1'b0;
			row_data_d   = 1'b0;
			res_valid    = row_data_q;
			res          = '0;
			res.row_end  = row_data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_comment_q <= 1'b0;
			in_escape_q  <= 1'b0;
			in_quote_q   <= 1'b0;
			last_quote_q <= 1'b0;
			row_data_q   <= 1'b0;
			kind_q       <= csvp_pkg::KIND_UNKNOWN;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				in_comment_q <= in_comment_d;
				in_escape_q  <= in_escape_d;
				in_quote_q   <= in_quote_d;
				last_quote_q <= last_quote_d;
				row_data_q   <= row_data_d;
				kind_q       <= kind_d;
				out_valid_q  <= res_valid;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			out_q <= res;
		end
	end

	// A comment is only opened at a field start and never while escaped.
	a_comment_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_comment_q |-> (kind_q == csvp_pkg::KIND_UNKNOWN) && !in_escape_q)
		else $error("comment active outside a field start");

	// End of input always leaves a clean row state behind.
	a_eoi_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_data.end_of_input |=>
			!in_quote_q && !in_comment_q && !in_escape_q && !row_data_q &&
			(kind_q == csvp_pkg::KIND_UNKNOWN))
		else $error("row state not cleared after end of input");

	// A row end result starts a fresh row with no data.
	a_row_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res_valid && res.row_end |=> !row_data_q && out_valid_q)
		else $error("row data flag still set after a row end");

	// Field and row ends carry a zero byte and never both at once.
	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.field_end || out_q.row_end) |->
			(out_q.out_byte == 8'h00) && !(out_q.field_end && out_q.row_end))
		else $error("marker item with non-zero byte");

	// An empty output register never holds back the input side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with an empty output register");

endmodule

### tb/sv/csv_row_field_parser_core_tb.sv
// ----------------------------------------------------------------------------
// CSV row field parser core testbench
// Feeds CSV text through the core under several separator and comment
// settings, with random gaps on both handshakes. A behavioural parser in the
// bench works out the cleaned bytes, field ends and row ends, and every item
// the core delivers is checked against the oldest one still due.
// ----------------------------------------------------------------------------
module csv_row_field_parser_core_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 340;
	localparam logic [csvp_pkg::CFG_INDEX_W-1:0] REG_UNUSED_FIRST =
		csvp_pkg::REG_KEEP_COMMENTS + 8'd1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	csvp_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	csvp_pkg::out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [csvp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [7:0] cfg_wdata = '0;

	csv_row_field_parser_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// Register copies and parse state of the bench's own parser.
	logic [7:0] sep_r = csvp_pkg::SEPARATOR_RESET;
	logic [7:0] cmt_a_r = '0;
	logic [7:0] cmt_b_r = '0;
	logic keep_r = 1'b0;
	logic in_cmt = 1'b0;
	logic in_esc = 1'b0;
	logic in_qt = 1'b0;
	logic prev_quote = 1'b0;
	logic row_live = 1'b0;
	csvp_pkg::kind_t field_kind_r = csvp_pkg::KIND_UNKNOWN;

	csvp_pkg::in_item_t source_q[$];
	csvp_pkg::out_item_t cleaned_q[$];
	int fed = 0;
	int consumed = 0;
	int errors = 0;
	int cycles = 0;
	int send_idle = 32;
	int recv_idle = 61;
	bit in_taken = 1'b0;

	function automatic bit blank(input logic [7:0] c);
		return c == csvp_pkg::CH_SPACE || (c >= csvp_pkg::CH_TAB && c <= csvp_pkg::CH_CR);
	endfunction

	function automatic void emit(input logic [7:0] b, input logic fe, input logic re);
		csvp_pkg::out_item_t r;
		r.out_byte = b;
		r.field_end = fe;
		r.row_end = re;
		cleaned_q.push_back(r);
	endfunction

	function automatic void close_row();
		bit had;
		had = row_live;
		in_cmt = 1'b0;
		in_esc = 1'b0;
		in_qt = 1'b0;
		field_kind_r = csvp_pkg::KIND_UNKNOWN;
		prev_quote = 1'b0;
		row_live = 1'b0;
		if (had) begin
			emit(8'h00, 1'b0, 1'b1);
		end
	endfunction

	function automatic void take_data(input logic [7:0] c);
		row_live = 1'b1;
		prev_quote = (c == csvp_pkg::CH_QUOTE);
		emit(c, 1'b0, 1'b0);
	endfunction

	function automatic void parse_char(input csvp_pkg::in_item_t it);
		logic [7:0] c;
		bit ws;
		c = it.in_byte;
		ws = (sep_r == 8'h00);
		if (it.end_of_input) begin
			close_row();
			return;
		end
		if (in_cmt) begin
			if (c == csvp_pkg::CH_LF) begin
				close_row();
			end else if (keep_r) begin
				row_live = 1'b1;
				emit(c, 1'b0, 1'b0);
			end
			return;
		end
		if (in_esc) begin
			in_esc = 1'b0;
			case (c)
				csvp_pkg::CH_N: c = csvp_pkg::CH_LF;
				csvp_pkg::CH_R: c = csvp_pkg::CH_CR;
				csvp_pkg::CH_T: c = csvp_pkg::CH_TAB;
				default: ;
			endcase
			take_data(c);
			return;
		end
		if (field_kind_r == csvp_pkg::KIND_UNKNOWN) begin
			if (ws && blank(c)) begin
				return;
			end
			if (c != 8'h00 && (c == cmt_a_r || c == cmt_b_r)) begin
				in_cmt = 1'b1;
				if (keep_r) begin
					row_live = 1'b1;
					emit(c, 1'b0, 1'b0);
				end
				return;
			end
			if (c == csvp_pkg::CH_QUOTE) begin
				field_kind_r = csvp_pkg::KIND_QUOTED;
				in_qt = 1'b1;
				prev_quote = 1'b0;
				return;
			end
			field_kind_r = csvp_pkg::KIND_UNQUOTED;
		end
		if (c == csvp_pkg::CH_QUOTE) begin
			in_qt = !in_qt;
			if (field_kind_r == csvp_pkg::KIND_QUOTED) begin
				if (prev_quote) begin
					prev_quote = 1'b0;
					row_live = 1'b1;
					emit(c, 1'b0, 1'b0);
				end else begin
					prev_quote = 1'b1;
				end
				return;
			end
			take_data(c);
			return;
		end
		if (c == csvp_pkg::CH_BSLASH) begin
			in_esc = 1'b1;
			return;
		end
		if (!in_qt) begin
			if (c == csvp_pkg::CH_CR) begin
				return;
			end
			if (c == csvp_pkg::CH_LF) begin
				close_row();
				return;
			end
			if ((ws && blank(c)) || c == sep_r) begin
				field_kind_r = csvp_pkg::KIND_UNKNOWN;
				row_live = 1'b1;
				prev_quote = 1'b0;
				emit(8'h00, 1'b1, 1'b0);
				return;
			end
		end else if (ws && blank(c)) begin
			return;
		end
		take_data(c);
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Source text generation.
	function automatic void feed_byte(input logic [7:0] b);
		csvp_pkg::in_item_t it;
		it.in_byte = b;
		it.end_of_input = 1'b0;
		source_q.push_back(it);
		fed++;
	endfunction

	function automatic void feed_end();
		csvp_pkg::in_item_t it;
		it.in_byte = 8'($urandom);
		it.end_of_input = 1'b1;
		source_q.push_back(it);
		fed++;
	endfunction

	function automatic void feed_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			feed_byte(s[i]);
		end
	endfunction

	function automatic logic [7:0] plain_char();
		case ($urandom_range(3))
			0: return 8'($urandom_range(8'h80, 8'hFF));
			1: return 8'(8'h30 + $urandom_range(9));
			default: return 8'(8'h61 + $urandom_range(25));
		endcase
	endfunction

	function automatic logic [7:0] gap_char();
		case ($urandom_range(3))
			0: return csvp_pkg::CH_SPACE;
			1: return csvp_pkg::CH_TAB;
			2: return csvp_pkg::CH_VT;
			default: return csvp_pkg::CH_FF;
		endcase
	endfunction

	function automatic void feed_field(input logic [7:0] sep);
		int n;
		bit quoted;
		n = $urandom_range(0, 6);
		quoted = ($urandom_range(2) == 0);
		if (sep == 8'h00 && $urandom_range(3) == 0) begin
			feed_byte(gap_char());
		end
		if (quoted) begin
			feed_byte(csvp_pkg::CH_QUOTE);
		end
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: begin
					feed_byte(csvp_pkg::CH_BSLASH);
					case ($urandom_range(4))
						0: feed_byte(csvp_pkg::CH_N);
						1: feed_byte(csvp_pkg::CH_R);
						2: feed_byte(csvp_pkg::CH_T);
						3: feed_byte(csvp_pkg::CH_BSLASH);
						default: feed_byte(plain_char());
					endcase
				end
				1: begin
					if (quoted) begin
						feed_byte(csvp_pkg::CH_QUOTE);
						feed_byte(csvp_pkg::CH_QUOTE);
					end else begin
						feed_byte(csvp_pkg::CH_QUOTE);
						feed_byte(plain_char());
						feed_byte(csvp_pkg::CH_QUOTE);
					end
				end
				2: begin
					if (quoted) begin
						feed_byte($urandom_range(1) ? csvp_pkg::CH_LF :
							(sep == 8'h00 ? gap_char() : sep));
					end else begin
						feed_byte(plain_char());
					end
				end
				default: feed_byte(plain_char());
			endcase
		end
		if (quoted) begin
			feed_byte(csvp_pkg::CH_QUOTE);
		end
	endfunction

	function automatic void feed_row(input logic [7:0] sep, input logic [7:0] cmt);
		int pick;
		int nf;
		pick = $urandom_range(99);
		if (pick < 8) begin
			repeat ($urandom_range(1, 8)) feed_byte(8'($urandom));
			return;
		end
		if (pick < 12) begin
			feed_byte(csvp_pkg::CH_LF);
			return;
		end
		if (pick < 20 && cmt != 8'h00) begin
			feed_byte(cmt);
			repeat ($urandom_range(0, 6)) feed_byte(plain_char());
			feed_byte(csvp_pkg::CH_LF);
			return;
		end
		nf = $urandom_range(1, 4);
		for (int f = 0; f < nf; f++) begin
			if (f != 0) begin
				feed_byte(sep == 8'h00 ? gap_char() : sep);
			end
			feed_field(sep);
		end
		pick = $urandom_range(99);
		if (pick < 10) begin
			feed_end();
		end else begin
			if (pick < 30) begin
				feed_byte(csvp_pkg::CH_CR);
			end
			feed_byte(csvp_pkg::CH_LF);
		end
	endfunction

	task automatic write_reg(input logic [csvp_pkg::CFG_INDEX_W-1:0] idx,
			input logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
	endtask

	task automatic configure(input logic [7:0] sep, input logic [7:0] a, input logic [7:0] b,
			input logic keep);
		write_reg(8'($urandom_range(REG_UNUSED_FIRST, 255)), 8'($urandom));
		write_reg(csvp_pkg::REG_FIELD_SEPARATOR, sep);
		write_reg(csvp_pkg::REG_COMMENT_CHAR_A, a);
		write_reg(csvp_pkg::REG_COMMENT_CHAR_B, b);
		write_reg(csvp_pkg::REG_KEEP_COMMENTS, {7'd0, keep});
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		do @(negedge clk); while (consumed != fed || cleaned_q.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic run_phase(input logic [7:0] sep, input logic [7:0] a, input logic [7:0] b,
			input logic keep, input int s_idle, input int r_idle);
		int start;
		configure(sep, a, b, keep);
		send_idle = s_idle;
		recv_idle = r_idle;
		start = fed;
		while (fed - start < PHASE_ITEMS) begin
			feed_row(sep, $urandom_range(1) ? a : b);
		end
		settle();
	endtask

	// Sender side: presents the next pending item, or idles; also sets out_ready at random.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (source_q.size() != 0 && $urandom_range(99) >= send_idle) begin
					in_data <= source_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Receiver side: checks delivered items, then parses the accepted one.
	always @(posedge clk) begin : watch
		csvp_pkg::out_item_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else if (arst_n) begin
			if (out_valid && out_ready) begin
				if (cleaned_q.size() == 0) begin
					$display("%0t: unexpected item, expected none, actual %h", $time, out_data);
					errors++;
				end else begin
					want = cleaned_q.pop_front();
					check_field("out_byte", want.out_byte, out_data.out_byte);
					check_field("field_end", {7'd0, want.field_end}, {7'd0, out_data.field_end});
					check_field("row_end", {7'd0, want.row_end}, {7'd0, out_data.row_end});
				end
			end
			in_taken = in_valid && in_ready;
			if (in_taken) begin
				parse_char(in_data);
				consumed++;
			end
			if (cfg_we) begin
				case (cfg_index)
					csvp_pkg::REG_FIELD_SEPARATOR: sep_r = cfg_wdata;
					csvp_pkg::REG_COMMENT_CHAR_A: cmt_a_r = cfg_wdata;
					csvp_pkg::REG_COMMENT_CHAR_B: cmt_b_r = cfg_wdata;
					csvp_pkg::REG_KEEP_COMMENTS: keep_r = cfg_wdata[0];
					default: ;
				endcase
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Quoted field with a doubled quote, a quote inside an unquoted field,
		// escapes, a dropped CR, an empty row, an unclosed quote cut off by
		// the end of input, and the extreme byte values.
		feed_text("\"a\"\"b\",c\"d\\n\\x\"");
		feed_byte(csvp_pkg::CH_CR);
		feed_byte(csvp_pkg::CH_LF);
		feed_byte(csvp_pkg::CH_LF);
		feed_text("\"o");
		feed_end();
		feed_byte(8'h00);
		feed_byte(8'hFF);
		feed_end();
		settle();

		run_phase(8'h00, "#", ";", 1'b1, 32, 61);
		run_phase(8'hFF, "#", 8'h00, 1'b0, 32, 61);
		run_phase(";", 8'h00, 8'hFF, 1'b1, 61, 32);
		run_phase(csvp_pkg::SEPARATOR_RESET, "#", "!", 1'b0, 61, 32);
		run_phase(8'h00, 8'h00, 8'h00, 1'b0, 0, 0);
		run_phase(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), 0, 0);

		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
